// ----- src/clcr_pkg.sv -----
// Package for the CR LF line command receiver: field widths, byte codes,
// command codes and keyword character tables. No dependencies.
package clcr_pkg;

    localparam int LEN_W = 6;
    localparam int IDLE_W = 20;
    localparam int BYTE_W = 8;
    localparam int CODE_W = 2;
    localparam int KW_N = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam int MAX_LINE_DEF = 62;

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = 20'd50000;

    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

    localparam logic [LEN_W-1:0] KW_START_LEN = 6'd5;
    localparam logic [LEN_W-1:0] KW_STOP_LEN = 6'd4;
    localparam logic [LEN_W-1:0] KW_STATUS_LEN = 6'd10;

    localparam logic [KW_N-1:0] MATCH_ALL = '1;

    // Register index taken from the word address.
    localparam logic [CFG_ADDR_W-3:0] REG_IDLE_TIMEOUT = 1'b0;

    typedef enum logic [CODE_W-1:0] {
        CMD_START   = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_STATUS  = 2'd2,
        CMD_UNKNOWN = 2'd3
    } t_cmd_code;

    typedef struct packed {
        logic       valid;
        t_cmd_code  code;
    } t_result;

    // Keyword characters by position; zero past the end never matches a
    // printable byte.
    function automatic logic [BYTE_W-1:0] kw_start_char(input logic [LEN_W-1:0] pos);
        case (pos)
            6'd0: return "S";
            6'd1: return "T";
            6'd2: return "A";
            6'd3: return "R";
            6'd4: return "T";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] kw_stop_char(input logic [LEN_W-1:0] pos);
        case (pos)
            6'd0: return "S";
            6'd1: return "T";
            6'd2: return "O";
            6'd3: return "P";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] kw_status_char(input logic [LEN_W-1:0] pos);
        case (pos)
            6'd0: return "G";
            6'd1: return "E";
            6'd2: return "T";
            6'd3: return "_";
            6'd4: return "S";
            6'd5: return "T";
            6'd6: return "A";
            6'd7: return "T";
            6'd8: return "U";
            6'd9: return "S";
            default: return 8'h00;
        endcase
    endfunction

endpackage

// ----- src/clcr_if.sv -----
// Stream interfaces of the line command receiver: byte and tick input,
// command code output. Depends on clcr_pkg.
interface clcr_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [clcr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface clcr_out_if;
    logic                         valid;
    logic                         ready;
    logic [clcr_pkg::CODE_W-1:0]  command_code;

    modport source (output valid, output command_code, input ready);
    modport sink (input valid, input command_code, output ready);
endinterface

// ----- src/clcr_regs.sv -----
// APB-style configuration register holding the idle timeout.
// Depends on clcr_pkg.
module clcr_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [clcr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [clcr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [clcr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [clcr_pkg::IDLE_W-1:0]      o_idle_timeout
);

    logic [clcr_pkg::IDLE_W-1:0] r_idle_timeout;
    logic                        sel_timeout;

    assign sel_timeout = (paddr[clcr_pkg::CFG_ADDR_W-1:2] == clcr_pkg::REG_IDLE_TIMEOUT);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= clcr_pkg::IDLE_TIMEOUT_RST;
        end else if (psel && penable && pwrite && sel_timeout) begin
            r_idle_timeout <= pwdata[clcr_pkg::IDLE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_timeout) begin
            prdata = {{(clcr_pkg::CFG_DATA_W - clcr_pkg::IDLE_W){1'b0}}, r_idle_timeout};
        end
    end

    assign o_idle_timeout = r_idle_timeout;

endmodule

// ----- src/clcr_parser.sv -----
// Line state and incremental keyword matcher; one transaction per cycle
// while the queue has space. Depends on clcr_pkg and clcr_in_if.
module clcr_parser #(
    parameter int MAX_LINE = clcr_pkg::MAX_LINE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    clcr_in_if.sink                      i_in,
    input  logic                         i_space,
    input  logic [clcr_pkg::IDLE_W-1:0]  i_idle_timeout,
    output clcr_pkg::t_result            o_result
);

    localparam logic [clcr_pkg::LEN_W-1:0] MAX_LEN = clcr_pkg::LEN_W'(MAX_LINE);

    logic [clcr_pkg::LEN_W-1:0]   r_len, n_len;
    logic                         r_cr, n_cr;
    logic                         r_disc, n_disc;
    logic [clcr_pkg::IDLE_W-1:0]  r_idle, n_idle;
    logic [clcr_pkg::KW_N-1:0]    r_match, n_match;

    logic                         accept;
    logic                         partial;
    logic                         printable;
    logic [clcr_pkg::IDLE_W-1:0]  idle_inc;
    logic [clcr_pkg::BYTE_W-1:0]  b;
    clcr_pkg::t_cmd_code          line_code;

    assign i_in.ready = i_space;
    assign accept = i_in.valid && i_space;
    assign b = i_in.rx_byte;
    assign partial = (r_len != '0) || r_cr || r_disc;
    assign printable = (b >= clcr_pkg::PRINT_LO) && (b <= clcr_pkg::PRINT_HI);
    assign idle_inc = (r_idle == clcr_pkg::IDLE_MAX) ? r_idle
                                                     : r_idle + clcr_pkg::IDLE_W'(1);

    always_comb begin
        if (r_match[0] && r_len == clcr_pkg::KW_START_LEN) begin
            line_code = clcr_pkg::CMD_START;
        end else if (r_match[1] && r_len == clcr_pkg::KW_STOP_LEN) begin
            line_code = clcr_pkg::CMD_STOP;
        end else if (r_match[2] && r_len == clcr_pkg::KW_STATUS_LEN) begin
            line_code = clcr_pkg::CMD_STATUS;
        end else begin
            line_code = clcr_pkg::CMD_UNKNOWN;
        end
    end

    always_comb begin
        logic clear;
        clear = 1'b0;
        n_len = r_len;
        n_cr = r_cr;
        n_disc = r_disc;
        n_idle = r_idle;
        n_match = r_match;
        o_result.valid = 1'b0;
        o_result.code = line_code;
        if (accept) begin
            if (i_in.op) begin
                // Ticks only count while a line is partial.
                if (partial) begin
                    n_idle = idle_inc;
                    if (idle_inc >= i_idle_timeout) begin
                        clear = 1'b1;
                    end
                end
            end else begin
                n_idle = '0;
                if (r_disc) begin
                    if (r_cr && b == clcr_pkg::BYTE_LF) begin
                        clear = 1'b1;
                    end else begin
                        n_cr = (b == clcr_pkg::BYTE_CR);
                    end
                end else if (r_cr) begin
                    if (b == clcr_pkg::BYTE_LF) begin
                        o_result.valid = 1'b1;
                        clear = 1'b1;
                    end else begin
                        n_disc = 1'b1;
                        n_cr = (b == clcr_pkg::BYTE_CR);
                    end
                end else if (b == clcr_pkg::BYTE_CR) begin
                    n_cr = 1'b1;
                end else if (!printable || r_len >= MAX_LEN) begin
                    n_disc = 1'b1;
                    n_cr = 1'b0;
                end else begin
                    n_match[0] = r_match[0] && (b == clcr_pkg::kw_start_char(r_len));
                    n_match[1] = r_match[1] && (b == clcr_pkg::kw_stop_char(r_len));
                    n_match[2] = r_match[2] && (b == clcr_pkg::kw_status_char(r_len));
                    n_len = r_len + clcr_pkg::LEN_W'(1);
                end
            end
        end
        if (clear) begin
            n_len = '0;
            n_cr = 1'b0;
            n_disc = 1'b0;
            n_idle = '0;
            n_match = clcr_pkg::MATCH_ALL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_cr <= 1'b0;
            r_disc <= 1'b0;
            r_idle <= '0;
            r_match <= clcr_pkg::MATCH_ALL;
        end else begin
            r_len <= n_len;
            r_cr <= n_cr;
            r_disc <= n_disc;
            r_idle <= n_idle;
            r_match <= n_match;
        end
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= MAX_LEN)
        else $error("line length beyond maximum");

    a_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !partial |-> r_idle == '0)
        else $error("idle count running on an empty line");

    a_result_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (accept && !i_in.op && r_cr && !r_disc))
        else $error("command emitted without a CR LF transaction");
`endif

endmodule

// ----- src/clcr_out_queue.sv -----
// Two-entry result queue between the parser and the output channel.
// Depends on clcr_pkg and clcr_out_if.
module clcr_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clcr_pkg::t_result  i_result,
    output logic               o_space,
    clcr_out_if.source         o_out
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [clcr_pkg::CODE_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]            r_wr_ptr;
    logic [PTR_W-1:0]            r_rd_ptr;
    logic [CNT_W-1:0]            r_count;
    logic                        push;
    logic                        pop;

    assign o_space = (r_count != CNT_W'(DEPTH));
    assign push = i_result.valid;
    assign pop = o_out.valid && o_out.ready;
    assign o_out.valid = (r_count != '0);
    assign o_out.command_code = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_result.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> o_space)
        else $error("result pushed into a full queue");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_count == '0) |=> o_out.valid)
        else $error("pushed result not presented");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- src/crlf_line_command_receiver.sv -----
// Top level of the CR LF line command receiver.
// Depends on clcr_pkg, clcr_if, clcr_regs, clcr_parser and clcr_out_queue.
// Usage:
//   i_in carries one transaction per received UART byte (op = 0) or per
//   microsecond tick (op = 1). Printable bytes build a line; CR LF ends it
//   and one command code (START, STOP, status query or unknown) leaves on
//   o_out. Malformed lines are dropped up to the next CR LF, and a partial
//   line is dropped after idle_timeout_us ticks without a byte.
//   The APB port holds idle_timeout_us at byte address 0; pready is
//   always high and a write lands at the access cycle.
// Throughput:
//   One input transaction per cycle while the queue has space. The
//   code for a line enters the result queue when the LF is taken. The
//   line state update is a single parser pass between its state registers.
// Reset:
//   i_rst_n is synchronous; it empties the line, clears the result queue
//   and sets the idle timeout to 50000.
// Stalls:
//   A two-entry queue holds codes while o_out.ready is low; i_in.ready
//   drops only when both entries are full.
module crlf_line_command_receiver #(
    parameter int MAX_LINE = clcr_pkg::MAX_LINE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    clcr_in_if.sink                          i_in,
    clcr_out_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [clcr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [clcr_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [clcr_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    logic [clcr_pkg::IDLE_W-1:0] idle_timeout;
    logic                        space;
    clcr_pkg::t_result           result;

    clcr_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_idle_timeout (idle_timeout)
    );

    clcr_parser #(
        .MAX_LINE (MAX_LINE)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_space        (space),
        .i_idle_timeout (idle_timeout),
        .o_result       (result)
    );

    clcr_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_space  (space),
        .o_out    (o_out)
    );

endmodule

// ----- tb/clcr_tb_pkg.sv -----
`timescale 1ns / 100ps
// Shared testbench definitions for the line command receiver: the operation
// codes of an input transaction. No dependencies.
package clcr_tb_pkg;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_item_op;

endpackage

// ----- tb/clcr_command_checker.sv -----
`timescale 1ns / 100ps
// Checker for the line command receiver: tracks the line state and the idle
// timeout register, predicts command codes and compares them on the output.
// Depends on clcr_pkg, clcr_tb_pkg and the stream interfaces in clcr_if.
module clcr_command_checker
    import clcr_pkg::*;
    import clcr_tb_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    clcr_in_if                     i_byte_ch,
    clcr_out_if                    i_code_ch,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    input  logic [CFG_DATA_W-1:0]  prdata,
    input  logic                   pready,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_unknown
);

    localparam int KW_START = 0;
    localparam int KW_STOP = 1;
    localparam int KW_STATUS = 2;

    logic [IDLE_W-1:0] timeout_us;
    logic [LEN_W-1:0]  line_len;
    logic              cr_pending;
    logic              dropping;
    logic [IDLE_W-1:0] quiet_us;
    logic [KW_N-1:0]   kw_alive;

    t_cmd_code expected_codes[$];
    int fail_total;
    int checked_total;
    int unknown_total;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        fail_total++;
    endtask

    task automatic clear_line();
        line_len = '0;
        cr_pending = 1'b0;
        dropping = 1'b0;
        quiet_us = '0;
        kw_alive = '1;
    endtask

    // True when byte b at position pos keeps the line a prefix of keyword k.
    function automatic logic kw_continues(input int k, input int unsigned pos,
                                          input logic [BYTE_W-1:0] b);
        string word;
        case (k)
            KW_START: word = "START";
            KW_STOP: word = "STOP";
            default: begin
                word = "GET_";
                word = {word, "STATUS"};
            end
        endcase
        if (pos >= word.len()) return 1'b0;
        return word[pos] == b;
    endfunction

    function automatic t_cmd_code line_command();
        if (kw_alive[KW_START] && line_len == 6'd5) return CMD_START;
        if (kw_alive[KW_STOP] && line_len == 6'd4) return CMD_STOP;
        if (kw_alive[KW_STATUS] && line_len == 6'd10) return CMD_STATUS;
        return CMD_UNKNOWN;
    endfunction

    task automatic advance_line(input logic op, input logic [BYTE_W-1:0] b);
        logic [KW_N-1:0] alive_next;
        if (op == OP_TICK) begin
            // Silence is only timed while something of a line is held.
            if (line_len != 0 || cr_pending || dropping) begin
                if (quiet_us != IDLE_MAX) quiet_us = quiet_us + 1'b1;
                if (quiet_us >= timeout_us) clear_line();
            end
        end else begin
            quiet_us = '0;
            if (dropping) begin
                if (cr_pending && b == BYTE_LF) clear_line();
                else cr_pending = (b == BYTE_CR);
            end else if (cr_pending) begin
                if (b == BYTE_LF) begin
                    expected_codes.push_back(line_command());
                    clear_line();
                end else begin
                    dropping = 1'b1;
                    cr_pending = (b == BYTE_CR);
                end
            end else if (b == BYTE_CR) begin
                cr_pending = 1'b1;
            end else if (b < PRINT_LO || b > PRINT_HI || line_len >= MAX_LINE) begin
                dropping = 1'b1;
                cr_pending = 1'b0;
            end else begin
                alive_next = kw_alive;
                for (int k = 0; k < KW_N; k++) begin
                    if (!kw_continues(k, line_len, b)) alive_next[k] = 1'b0;
                end
                kw_alive = alive_next;
                line_len = line_len + 1'b1;
            end
        end
    endtask

    task automatic check_code(input logic [CODE_W-1:0] got);
        t_cmd_code want;
        if (expected_codes.size() == 0) begin
            report_mismatch($sformatf("command code %0d arrived with none expected", got));
        end else begin
            want = expected_codes.pop_front();
            checked_total++;
            if (want == CMD_UNKNOWN) unknown_total++;
            if (got !== want) begin
                report_mismatch($sformatf("command_code is %0d, expected %0d", got, want));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timeout_us = IDLE_TIMEOUT_RST;
            clear_line();
            expected_codes.delete();
        end else begin
            if (psel && penable && pready && paddr[CFG_ADDR_W-1:2] == REG_IDLE_TIMEOUT) begin
                if (pwrite) begin
                    timeout_us = pwdata[IDLE_W-1:0];
                end else if (prdata[IDLE_W-1:0] !== timeout_us) begin
                    report_mismatch($sformatf("idle timeout reads %0d, expected %0d",
                                              prdata[IDLE_W-1:0], timeout_us));
                end
            end
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                advance_line(i_byte_ch.op, i_byte_ch.rx_byte);
            end
            if (i_code_ch.valid && i_code_ch.ready) begin
                check_code(i_code_ch.command_code);
            end
        end
        o_fail_count <= fail_total;
        o_pending <= expected_codes.size();
        o_checked <= checked_total;
        o_unknown <= unknown_total;
    end

endmodule

// ----- tb/tb_crlf_line_command_receiver.sv -----
`timescale 1ns / 100ps
// Testbench top for the line command receiver: clock, reset, register setup,
// line stimulus, output pacing and the verdict. Depends on clcr_pkg,
// clcr_tb_pkg, clcr_if, clcr_command_checker and crlf_line_command_receiver.
module tb_crlf_line_command_receiver;
    import clcr_pkg::*;
    import clcr_tb_pkg::*;

    localparam int unsigned ITEM_TARGET = 1550;
    localparam int unsigned SINK_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;
    localparam int unsigned PHASES = 5;
    localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = {REG_IDLE_TIMEOUT, 2'b00};

    typedef enum int {
        SINK_FREE,
        SINK_COIN,
        SINK_SLOW,
        SINK_COMB
    } t_sink_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    logic steady_send = 1'b0;
    int unsigned burst_left = 0;
    int unsigned items_sent = 0;
    int unsigned ticks_sent = 0;

    int fail_count;
    int pending;
    int checked;
    int unknown_seen;

    clcr_in_if in_if();
    clcr_out_if out_if();

    crlf_line_command_receiver i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    clcr_command_checker #(
        .MAX_LINE (MAX_LINE_DEF)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_ch    (in_if),
        .i_code_ch    (out_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_unknown    (unknown_seen)
    );

    always #4 i_clk = ~i_clk;

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d command codes outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

    // Output pacing: random modes, plus one long hold-off on request.
    initial begin : sink_pacing
        t_sink_mode mode;
        int unsigned mode_left;
        mode = SINK_FREE;
        mode_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_ack) begin
                out_if.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                hold_ack <= 1'b1;
            end else begin
                hold_ack <= hold_req;
                if (mode_left == 0) begin
                    mode = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 200);
                end
                mode_left--;
                case (mode)
                    SINK_FREE: out_if.ready <= 1'b1;
                    SINK_COIN: out_if.ready <= 1'($urandom_range(0, 1));
                    SINK_SLOW: out_if.ready <= ($urandom_range(0, 3) == 0);
                    default: out_if.ready <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(input logic [CFG_ADDR_W-1:0] addr);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // One input transaction; valid stays high through a burst.
    task automatic send_item(input t_item_op op, input logic [BYTE_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = steady_send ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_if.valid <= 1'b1;
        in_if.op <= op;
        in_if.rx_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        burst_left--;
        items_sent++;
        if (op == OP_TICK) ticks_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
    endtask

    task automatic send_crlf();
        send_item(OP_BYTE, BYTE_CR);
        send_item(OP_BYTE, BYTE_LF);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic maybe_ticks(input int unsigned span);
        if ($urandom_range(0, 7) == 0) send_ticks($urandom_range(1, span));
    endtask

    function automatic logic [BYTE_W-1:0] printable();
        return BYTE_W'($urandom_range(PRINT_LO, PRINT_HI));
    endfunction

    task automatic send_random_line(input int unsigned span);
        logic [BYTE_W-1:0] body[$];
        string word;
        int unsigned kind;
        int unsigned pick;
        int unsigned pos;
        logic [BYTE_W-1:0] bad;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0: word = "START";
            1: word = "STOP";
            default: begin
                word = "GET_";
                word = {word, "STATUS"};
            end
        endcase
        if (kind < 84) begin
            for (int i = 0; i < word.len(); i++) body.push_back(word[i]);
        end
        if (kind >= 40 && kind < 55) begin
            // Near misses: one character changed, a prefix, or one too many.
            pick = $urandom_range(0, 2);
            pos = $urandom_range(0, body.size() - 1);
            case (pick)
                0: body[pos] = printable();
                1: void'(body.pop_back());
                default: body.push_back(printable());
            endcase
        end else if (kind >= 55 && kind < 70) begin
            body.delete();
            repeat ($urandom_range(0, 12)) body.push_back(printable());
        end else if (kind >= 70 && kind < 74) begin
            body.delete();
            repeat ($urandom_range(MAX_LINE_DEF - 1, MAX_LINE_DEF + 2)) begin
                body.push_back(printable());
            end
        end else if (kind >= 74 && kind < 84) begin
            case ($urandom_range(0, 3))
                0: bad = BYTE_CR;
                1: bad = BYTE_LF;
                2: bad = BYTE_W'($urandom_range(0, 31));
                default: bad = BYTE_W'($urandom_range(127, 255));
            endcase
            body.insert($urandom_range(0, body.size()), bad);
        end else if (kind >= 84) begin
            repeat ($urandom_range(1, 6)) body.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        maybe_ticks(span);
        foreach (body[i]) begin
            maybe_ticks(span);
            send_item(OP_BYTE, body[i]);
        end
        pick = $urandom_range(0, 19);
        if (pick < 18) begin
            maybe_ticks(span);
            send_item(OP_BYTE, BYTE_CR);
            maybe_ticks(span);
            send_item(OP_BYTE, BYTE_LF);
        end else if (pick == 18) begin
            send_item(OP_BYTE, BYTE_CR);
        end
    endtask

    task automatic wait_for_drain();
        int unsigned waited;
        waited = 0;
        in_if.valid <= 1'b0;
        burst_left = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned phase_timeouts[PHASES];
        int unsigned target;
        int unsigned span;
        in_if.valid <= 1'b0;
        in_if.op <= OP_BYTE;
        in_if.rx_byte <= '0;
        phase_timeouts = '{1, 1000000, 3, 0, 50000};
        phase_timeouts[3] = $urandom_range(2, 16);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_read(TIMEOUT_ADDR);
        apb_write(TIMEOUT_ADDR, 2);
        apb_read(TIMEOUT_ADDR);

        // Directed lines with a two microsecond timeout.
        send_text("STOP");
        send_crlf();
        send_crlf();
        send_text("STOP");
        send_ticks(2);
        send_crlf();
        send_item(OP_BYTE, BYTE_LF);
        send_crlf();
        send_item(OP_BYTE, BYTE_CR);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_crlf();
        wait_for_drain();

        // Hold the output long enough that the result queue fills and the
        // input stalls, then let everything drain.
        hold_req <= 1'b1;
        repeat (8) begin
            send_text("STOP");
            send_crlf();
        end
        while (!hold_ack) @(posedge i_clk);
        hold_req <= 1'b0;
        wait_for_drain();

        for (int p = 0; p < PHASES; p++) begin
            apb_write(TIMEOUT_ADDR, phase_timeouts[p]);
            apb_read(TIMEOUT_ADDR);
            span = (phase_timeouts[p] <= 64) ? 2 * phase_timeouts[p] : 6;
            steady_send <= (p == 2);
            target = items_sent + (ITEM_TARGET - items_sent) / (PHASES - p);
            while (items_sent < target) send_random_line(span);
            wait_for_drain();
        end

        $display("Summary: %0d transactions sent (%0d ticks) across six timeout settings",
                 items_sent, ticks_sent);
        $display("Summary: %0d command codes checked, %0d of them unknown",
                 checked, unknown_seen);
        if (pending != 0) begin
            $display("%0d command codes never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
